@@ src/tae_pkg.sv @@
// Shared types and codes for the Thumb ALU execute block.
// No dependencies; every other file in src imports this package.
package tae_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [3:0] {
        FUNC_AND = 4'd0,
        FUNC_EOR = 4'd1,
        FUNC_LSL = 4'd2,
        FUNC_LSR = 4'd3,
        FUNC_ASR = 4'd4,
        FUNC_ADC = 4'd5,
        FUNC_SBC = 4'd6,
        FUNC_ROR = 4'd7,
        FUNC_TST = 4'd8,
        FUNC_NEG = 4'd9,
        FUNC_CMP = 4'd10,
        FUNC_CMN = 4'd11,
        FUNC_ORR = 4'd12,
        FUNC_MUL = 4'd13,
        FUNC_BIC = 4'd14,
        FUNC_MVN = 4'd15
    } alu_func_t;

    typedef struct packed {
        alu_func_t           func;
        logic [DATA_W-1:0]   dest_value;
        logic [DATA_W-1:0]   source_value;
        logic                carry_in;
        logic                overflow_in;
    } cmd_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]   result;
        logic                write_back;
        logic                flag_n;
        logic                flag_z;
        logic                flag_c;
        logic                flag_v;
    } rsp_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic                carry;
    } shift_res_t;

endpackage

@@ src/thumb_alu_execute.sv @@
// Thumb ALU execute: input register, one combinational ALU pass, result register.
// An accepted item passes through the input register and then the result register before it leaves;
// throughput is one item per cycle while rsp_stall is low, set by the single ALU pass and
// 32x32 multiplier between the registers.
// A stalled result holds while the input register, if empty, still takes one more item.
// rst_n clears both valid flags asynchronously; payload registers are not reset.
// Depends on tae_pkg and tae_alu.
module thumb_alu_execute (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  tae_pkg::cmd_item_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tae_pkg::rsp_item_t rsp
);
    import tae_pkg::*;

    logic      stage_valid_reg;
    cmd_item_t stage_item_reg;
    logic      rsp_valid_reg;
    rsp_item_t rsp_item_reg;
    rsp_item_t alu_out;
    logic      rsp_advance;
    logic      stage_advance;

    tae_alu u_alu (
        .cmd (stage_item_reg),
        .rsp (alu_out)
    );

    assign rsp_advance   = !rsp_valid_reg || !rsp_stall;
    assign stage_advance = !stage_valid_reg || rsp_advance;
    assign cmd_stall     = !stage_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (stage_advance)
            begin
                stage_valid_reg <= cmd_valid;
            end
            if (rsp_advance)
            begin
                rsp_valid_reg <= stage_valid_reg;
            end
        end
    end

    // Hold payload while its stage is stalled
    always_ff @(posedge clk)
    begin
        if (stage_advance && cmd_valid)
        begin
            stage_item_reg <= cmd;
        end
        if (rsp_advance && stage_valid_reg)
        begin
            rsp_item_reg <= alu_out;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_item_reg;

endmodule

@@ src/tae_shifter.sv @@
// Barrel shifter for LSL, LSR, ASR and ROR with ARM carry-out rules.
// Depends on tae_pkg.
module tae_shifter (
    input  tae_pkg::alu_func_t  func,
    input  logic [31:0]         dest_value,
    input  logic [7:0]          amount,
    input  logic                carry_in,
    output tae_pkg::shift_res_t shift_out
);
    import tae_pkg::*;

    logic [4:0]  sh;
    logic        amt_zero;
    logic        amt_is_32;
    logic        amt_over_32;
    logic [32:0] lsl_wide;
    logic [32:0] lsr_wide;
    logic [32:0] asr_wide;
    logic [63:0] ror_wide;

    assign sh          = amount[4:0];
    assign amt_zero    = (amount == 8'd0);
    assign amt_is_32   = (amount == 8'd32);
    assign amt_over_32 = (amount > 8'd32);

    // Carry falls out of the extra bit next to the operand
    assign lsl_wide = {1'b0, dest_value} << sh;
    assign lsr_wide = {dest_value, 1'b0} >> sh;
    assign asr_wide = 33'($signed({dest_value, 1'b0}) >>> sh);
    assign ror_wide = {dest_value, dest_value} >> sh;

    always_comb
    begin
        shift_out.value = dest_value;
        shift_out.carry = carry_in;
        if (!amt_zero)
        begin
            case (func)
                FUNC_LSL:
                begin
                    if (amt_is_32)
                    begin
                        shift_out.value = '0;
                        shift_out.carry = dest_value[0];
                    end
                    else if (amt_over_32)
                    begin
                        shift_out.value = '0;
                        shift_out.carry = 1'b0;
                    end
                    else
                    begin
                        shift_out.value = lsl_wide[31:0];
                        shift_out.carry = lsl_wide[32];
                    end
                end
                FUNC_LSR:
                begin
                    if (amt_is_32)
                    begin
                        shift_out.value = '0;
                        shift_out.carry = dest_value[31];
                    end
                    else if (amt_over_32)
                    begin
                        shift_out.value = '0;
                        shift_out.carry = 1'b0;
                    end
                    else
                    begin
                        shift_out.value = lsr_wide[32:1];
                        shift_out.carry = lsr_wide[0];
                    end
                end
                FUNC_ASR:
                begin
                    if (amt_is_32 || amt_over_32)
                    begin
                        shift_out.value = {32{dest_value[31]}};
                        shift_out.carry = dest_value[31];
                    end
                    else
                    begin
                        shift_out.value = asr_wide[32:1];
                        shift_out.carry = asr_wide[0];
                    end
                end
                FUNC_ROR:
                begin
                    // Multiples of 32 leave the value, carry is bit 31 either way
                    shift_out.value = ror_wide[31:0];
                    shift_out.carry = ror_wide[31];
                end
                default:
                begin
                    shift_out.value = dest_value;
                    shift_out.carry = carry_in;
                end
            endcase
        end
    end

endmodule

@@ src/tae_alu.sv @@
// Combinational datapath: shared adder, shifter, multiplier, logic ops, flags.
// Depends on tae_pkg and tae_shifter.
module tae_alu (
    input  tae_pkg::cmd_item_t cmd,
    output tae_pkg::rsp_item_t rsp
);
    import tae_pkg::*;

    shift_res_t  shift_out;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_cin;
    logic [32:0] add_sum;
    logic        add_v;
    logic [31:0] product;
    logic [31:0] result;
    logic        flag_c;
    logic        flag_v;
    logic        write_back;

    tae_shifter u_shifter (
        .func       (cmd.func),
        .dest_value (cmd.dest_value),
        .amount     (cmd.source_value[7:0]),
        .carry_in   (cmd.carry_in),
        .shift_out  (shift_out)
    );

    // Subtractions run as a + ~b + carry on the one adder
    always_comb
    begin
        add_a   = cmd.dest_value;
        add_b   = cmd.source_value;
        add_cin = 1'b0;
        case (cmd.func)
            FUNC_ADC:
            begin
                add_cin = cmd.carry_in;
            end
            FUNC_SBC:
            begin
                add_b   = ~cmd.source_value;
                add_cin = cmd.carry_in;
            end
            FUNC_CMP:
            begin
                add_b   = ~cmd.source_value;
                add_cin = 1'b1;
            end
            FUNC_NEG:
            begin
                add_a   = '0;
                add_b   = ~cmd.source_value;
                add_cin = 1'b1;
            end
            default:
            begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
    assign add_v   = (add_a[31] ^ add_sum[31]) & (add_b[31] ^ add_sum[31]);
    assign product = cmd.dest_value * cmd.source_value;

    always_comb
    begin
        result     = '0;
        flag_c     = cmd.carry_in;
        flag_v     = cmd.overflow_in;
        write_back = 1'b1;
        unique case (cmd.func)
            FUNC_AND: result = cmd.dest_value & cmd.source_value;
            FUNC_EOR: result = cmd.dest_value ^ cmd.source_value;
            FUNC_LSL, FUNC_LSR, FUNC_ASR, FUNC_ROR:
            begin
                result = shift_out.value;
                flag_c = shift_out.carry;
            end
            FUNC_ADC, FUNC_SBC, FUNC_NEG:
            begin
                result = add_sum[31:0];
                flag_c = add_sum[32];
                flag_v = add_v;
            end
            FUNC_TST:
            begin
                result     = cmd.dest_value & cmd.source_value;
                write_back = 1'b0;
            end
            FUNC_CMP, FUNC_CMN:
            begin
                result     = add_sum[31:0];
                flag_c     = add_sum[32];
                flag_v     = add_v;
                write_back = 1'b0;
            end
            FUNC_ORR: result = cmd.dest_value | cmd.source_value;
            FUNC_MUL: result = product;
            FUNC_BIC: result = cmd.dest_value & ~cmd.source_value;
            FUNC_MVN: result = ~cmd.source_value;
            default:  result = '0;
        endcase
    end

    assign rsp.result     = result;
    assign rsp.write_back = write_back;
    assign rsp.flag_n     = result[31];
    assign rsp.flag_z     = (result == '0);
    assign rsp.flag_c     = flag_c;
    assign rsp.flag_v     = flag_v;

endmodule
